// ===== hdl/rcddm_pkg.sv =====
// rcddm_pkg: types, constants and premix functions for the differential-drive mixer.
// No dependencies; imported by every module of the mixer.
`timescale 1ns / 1ps
`default_nettype none

package rcddm_pkg;

	typedef logic signed [7:0] axis_t;
	typedef logic signed [9:0] premix_t;
	typedef logic signed [8:0] pivot_t;
	typedef logic [1:0]        dir_t;

	localparam int          PULSE_W     = 12;
	localparam logic [11:0] PULSE_LO    = 12'd1000;
	localparam logic [11:0] PULSE_HI    = 12'd2000;
	localparam logic [5:0]  AXIS_MUL    = 6'd51;
	localparam logic [15:0] AXIS_RECIP  = 16'd41944;
	localparam int          RECIP_SHIFT = 20;
	localparam logic [8:0]  PIVOT_LIMIT = 9'd32;

	localparam dir_t DIR_STOP = 2'b00;
	localparam dir_t DIR_FWD  = 2'b01;
	localparam dir_t DIR_REV  = 2'b11;

	localparam logic [7:0] REG_LEFT_MIN  = 8'd0;
	localparam logic [7:0] REG_RIGHT_MIN = 8'd1;

	function automatic premix_t premix_left(axis_t x, axis_t y);
		premix_t p;
		if (y >= 0) begin
			p = (x >= 0) ? 10'sd127 : 10'sd127 + premix_t'(x);
		end else begin
			p = (x >= 0) ? 10'sd127 - premix_t'(x) : 10'sd127;
		end
		return p;
	endfunction

	function automatic premix_t premix_right(axis_t x, axis_t y);
		premix_t p;
		if (y >= 0) begin
			p = (x >= 0) ? 10'sd127 - premix_t'(x) : 10'sd127;
		end else begin
			p = (x >= 0) ? 10'sd127 : 10'sd127 + premix_t'(x);
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/rcddm_axis.sv =====
// rcddm_axis: saturates one pulse width and maps it to a signed axis value (stages 1-2).
// Depends on rcddm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcddm_axis
	import rcddm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [PULSE_W-1:0] pulse,
	output axis_t                   axis_s2
);

	logic [9:0]  span;
	logic [15:0] scaled_s1;
	logic [28:0] prod;

	always_comb begin
		if (pulse < PULSE_LO) begin
			span = 10'd0;
		end else if (pulse > PULSE_HI) begin
			span = 10'(PULSE_HI - PULSE_LO);
		end else begin
			span = 10'(pulse - PULSE_LO);
		end
	end

	// span*255/1000 == (span*51/8)/25, the divide by 25 done by reciprocal
	always_ff @(posedge clk) begin
		if (en) begin
			scaled_s1 <= 16'(span) * 16'(AXIS_MUL);
		end
	end

	assign prod = 29'(scaled_s1[15:3]) * 29'(AXIS_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			axis_s2 <= {~prod[RECIP_SHIFT+7], prod[RECIP_SHIFT+6:RECIP_SHIFT]};
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rcddm_mix.sv =====
// rcddm_mix: scales one motor's premix by throttle and blends in the pivot (stages 3-5).
// Depends on rcddm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcddm_mix
	import rcddm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    en,
	input  wire premix_t premix,
	input  wire pivot_t  pivot,
	input  wire axis_t   y,
	output axis_t        mix_s5
);

	logic [8:0]          ay;
	logic                big;
	logic [5:0]          ay_small;
	logic [5:0]          gap;
	logic signed [17:0]  pty_s3;
	logic signed [15:0]  piv_s3;
	logic [5:0]          ay_s3;
	logic                big_s3;
	logic signed [24:0]  num_d;
	logic signed [24:0]  num_s4;
	logic                big_s4;
	logic signed [24:0]  bias;
	logic signed [24:0]  quo;

	assign ay       = (y < 0) ? 9'(-(9'(y))) : 9'(y);
	assign big      = (ay > PIVOT_LIMIT);
	assign ay_small = big ? 6'd0 : ay[5:0];
	assign gap      = big ? 6'd0 : 6'(PIVOT_LIMIT - ay);

	always_ff @(posedge clk) begin
		if (en) begin
			pty_s3 <= 18'(premix) * 18'(y);
			piv_s3 <= 16'(signed'({1'b0, gap})) * 16'(pivot);
			ay_s3  <= ay_small;
			big_s3 <= big;
		end
	end

	always_comb begin
		if (big_s3) begin
			num_d = 25'(pty_s3);
		end else begin
			num_d = 25'(signed'({1'b0, ay_s3})) * 25'(pty_s3) + (25'(piv_s3) <<< 7);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= num_d;
			big_s4 <= big_s3;
		end
	end

	// truncate toward zero: bias negatives before the arithmetic shift
	always_comb begin
		if (num_s4 < 0) begin
			bias = big_s4 ? 25'sd127 : 25'sd4095;
		end else begin
			bias = 25'sd0;
		end
		quo = big_s4 ? ((num_s4 + bias) >>> 7) : ((num_s4 + bias) >>> 12);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (quo > 25'sd127) begin
				mix_s5 <= 8'sd127;
			end else if (quo < -25'sd128) begin
				mix_s5 <= -8'sd128;
			end else begin
				mix_s5 <= axis_t'(quo);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rcddm_drive.sv =====
// rcddm_drive: maps one motor's mix to duty, direction and floor (stage 6).
// Depends on rcddm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcddm_drive
	import rcddm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       en,
	input  wire axis_t      mix,
	input  wire logic [7:0] min_speed,
	output logic [7:0]      speed_s6,
	output dir_t            dir_s6,
	output logic [7:0]      floor_s6
);

	logic [7:0] mag;
	logic [6:0] dec;
	logic [7:0] raw;
	logic [7:0] flr;

	assign mag = (mix < 0) ? 8'(-(9'(mix))) : 8'(mix);
	assign dec = 7'(mag - 8'd1);

	// (mag-1)*255/127 == 2*(mag-1) + ((mag-1) == 127)
	always_comb begin
		if (mag == 8'd0) begin
			raw = 8'd0;
		end else begin
			raw = {dec, 1'b0} + 8'(dec == 7'd127);
		end
		flr = (raw == 8'd0) ? 8'd0 : min_speed;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			speed_s6 <= (raw < flr) ? flr : raw;
			floor_s6 <= flr;
			if (mix > 0) begin
				dir_s6 <= DIR_FWD;
			end else if (mix < 0) begin
				dir_s6 <= DIR_REV;
			end else begin
				dir_s6 <= DIR_STOP;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rc_differential_drive_mixer_top.sv =====
// rc_differential_drive_mixer_top: six-stage differential-drive mixer for two RC pulses.
// Depends on rcddm_pkg, rcddm_axis, rcddm_mix, rcddm_drive.
//
// channel  dir  handshake             payload
// s_*      in   s_tvalid / s_tready   s_tdata: steer_pulse, throttle_pulse
// m_*      out  m_tvalid / m_tready   m_tdata: speeds, dirs, floors
// cfg_*    in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transfer per cycle in and out while the output is not held by m_tready.
// The stage count is set by the pulse-to-axis reciprocal and the two-multiply pivot blend.
// A stall on m_tready holds every stage; s_tready drops only while the output is held.
// Reset clears the stage valid bits and both floor registers; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module rc_differential_drive_mixer_top
	import rcddm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [11:0] steer_pulse, [23:12] throttle_pulse
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [7:0] left_speed, [9:8] left_dir,
	                                    // [17:10] right_speed, [19:18] right_dir,
	                                    // [27:20] left_floor, [35:28] right_floor, zero pad
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic       adv;
	logic       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [7:0] left_min_q;
	logic [7:0] right_min_q;
	axis_t      x_s2;
	axis_t      y_s2;
	axis_t      mix_l_s5;
	axis_t      mix_r_s5;
	logic [7:0] spd_l_s6, spd_r_s6, flr_l_s6, flr_r_s6;
	dir_t       dir_l_s6, dir_r_s6;

	assign adv       = !vld_s6 || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_min_q  <= 8'd0;
			right_min_q <= 8'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LEFT_MIN:  left_min_q  <= cfg_data;
				REG_RIGHT_MIN: right_min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	rcddm_axis u_axis_x (
		.clk     (clk),
		.en      (adv),
		.pulse   (s_tdata[11:0]),
		.axis_s2 (x_s2)
	);

	rcddm_axis u_axis_y (
		.clk     (clk),
		.en      (adv),
		.pulse   (s_tdata[23:12]),
		.axis_s2 (y_s2)
	);

	rcddm_mix u_mix_l (
		.clk    (clk),
		.en     (adv),
		.premix (premix_left(x_s2, y_s2)),
		.pivot  (pivot_t'(x_s2)),
		.y      (y_s2),
		.mix_s5 (mix_l_s5)
	);

	rcddm_mix u_mix_r (
		.clk    (clk),
		.en     (adv),
		.premix (premix_right(x_s2, y_s2)),
		.pivot  (pivot_t'(-(pivot_t'(x_s2)))),
		.y      (y_s2),
		.mix_s5 (mix_r_s5)
	);

	rcddm_drive u_drive_l (
		.clk       (clk),
		.en        (adv),
		.mix       (mix_l_s5),
		.min_speed (left_min_q),
		.speed_s6  (spd_l_s6),
		.dir_s6    (dir_l_s6),
		.floor_s6  (flr_l_s6)
	);

	rcddm_drive u_drive_r (
		.clk       (clk),
		.en        (adv),
		.mix       (mix_r_s5),
		.min_speed (right_min_q),
		.speed_s6  (spd_r_s6),
		.dir_s6    (dir_r_s6),
		.floor_s6  (flr_r_s6)
	);

	assign m_tvalid = vld_s6;
	assign m_tdata  = {4'd0, flr_r_s6, flr_l_s6, dir_r_s6, spd_r_s6, dir_l_s6, spd_l_s6};

	a_left_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && flr_l_s6 != 8'd0) |-> (spd_l_s6 >= flr_l_s6 && dir_l_s6 != DIR_STOP))
		else $error("left floor applied without drive");

	a_right_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (dir_r_s6 != 2'b10 && dir_l_s6 != 2'b10))
		else $error("invalid direction code");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !vld_s5) |=> !m_tvalid)
		else $error("output repeated after transfer");

endmodule

`default_nettype wire
